/* hw/rtl/winograd_filter_transform_macros.svh */
// Assertion macros for the Winograd filter transform RTL.
// Included by the modules that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef WINOGRAD_FILTER_TRANSFORM_MACROS_SVH
`define WINOGRAD_FILTER_TRANSFORM_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define WFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define WFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

/* hw/rtl/wft_pkg.sv */
// Shared types and constants for the Winograd F(2x2,3x3) filter transform.
// No dependencies; used by winograd_filter_transform.
package wft_pkg;

  // Geometry and field widths.
  localparam int TileSize    = 4;
  localparam int MaxChannels = 1024;
  localparam int WeightW     = 16;
  localparam int ValW        = 20;
  localparam int IdxW        = 24;
  localparam int ChanW       = 10;
  localparam int CfgW        = 11;
  localparam int CfgIdxW     = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegNumOutputs  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegNumChannels = CfgIdxW'(1);

  typedef logic signed [ValW-1:0] val_t;

  // One filter request.
  typedef struct packed {
    logic signed [WeightW-1:0] w00;
    logic signed [WeightW-1:0] w01;
    logic signed [WeightW-1:0] w02;
    logic signed [WeightW-1:0] w10;
    logic signed [WeightW-1:0] w11;
    logic signed [WeightW-1:0] w12;
    logic signed [WeightW-1:0] w20;
    logic signed [WeightW-1:0] w21;
    logic signed [WeightW-1:0] w22;
    logic [ChanW-1:0]          out_chan;
    logic [ChanW-1:0]          in_chan;
  } in_req_t;

  // One transformed tile row.
  typedef struct packed {
    logic [1:0]        tile_row;
    val_t              val0;
    val_t              val1;
    val_t              val2;
    val_t              val3;
    logic [IdxW-1:0]   base_index;
    logic              last_row;
  } out_rsp_t;

  // Channel counts above the supported maximum are held at the maximum.
  function automatic logic [CfgW-1:0] clamp_count(input logic [CfgW-1:0] v);
    logic [CfgW-1:0] lim;
    lim = CfgW'(MaxChannels);
    return (v > lim) ? lim : v;
  endfunction

endpackage

/* hw/rtl/winograd_filter_transform.sv */
// Winograd F(2x2,3x3) filter transform: turns one 3x3 filter into four 4-value tile rows.
// Depends on wft_pkg and winograd_filter_transform_macros.svh.
//
// Each accepted filter (nine signed Q1.14 weights plus its output and input channel)
// yields four results, tile rows 0..3 of G*f*G^T, each with four exact 20-bit values
// (16 fraction bits) and the destination index xi*4*O*C + c*O + o, taken modulo 2^24.
// The datapath has three register stages: column transform with the c*O product,
// row transform with the base index, and a four-row output buffer that issues one row
// per cycle while out_ready_i is high. The first row is shown once the filter has moved
// through stages 1 and 2 into the output buffer, which sets the sustained rate; the two
// stages ahead of it hold up to two further filters, so input requests are taken while
// rows drain. Configuration writes are taken in every cycle and must only happen while the
// block is idle; a write to an index other than 0 or 1 is ignored.
`include "winograd_filter_transform_macros.svh"

module winograd_filter_transform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Filter requests.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wft_pkg::in_req_t              in_req_i,
  // Tile rows.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wft_pkg::out_rsp_t             out_rsp_o,
  // Configuration writes.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wft_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wft_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int ValW = wft_pkg::ValW;
  localparam int IdxW = wft_pkg::IdxW;
  localparam int OcW  = 2 * wft_pkg::CfgW;
  localparam int CoW  = wft_pkg::ChanW + wft_pkg::CfgW;
  localparam logic [1:0] LastRow = 2'(wft_pkg::TileSize - 1);

  // Configuration registers and the derived O*C product.
  logic [wft_pkg::CfgW-1:0] num_outputs_q, num_channels_q;
  logic [OcW-1:0]           oc_q, oc_d;
  logic [IdxW-1:0]          step_q, step_d;

  assign cfg_ready_o = 1'b1;
  assign oc_d        = OcW'(num_outputs_q) * OcW'(num_channels_q);
  assign step_d      = IdxW'({oc_q, 2'b00});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_outputs_q  <= wft_pkg::CfgW'(1);
      num_channels_q <= wft_pkg::CfgW'(1);
      oc_q           <= OcW'(1);
      step_q         <= IdxW'(4);
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          wft_pkg::RegNumOutputs:  num_outputs_q  <= wft_pkg::clamp_count(cfg_data_i);
          wft_pkg::RegNumChannels: num_channels_q <= wft_pkg::clamp_count(cfg_data_i);
          default: ;
        endcase
      end
      oc_q   <= oc_d;
      step_q <= step_d;
    end
  end

  // Pipeline flow control.
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic [1:0] s3_row_q;
  logic s1_ready, s2_ready, s3_load, out_take, s3_last;

  assign s3_last    = (s3_row_q == LastRow);
  assign out_take   = s3_valid_q && out_ready_i;
  assign s3_load    = s2_valid_q && (!s3_valid_q || (out_take && s3_last));
  assign s2_ready   = !s2_valid_q || s3_load;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Stage 1: scale to 16 fraction bits and apply G down each column; form c*O.
  wft_pkg::val_t    s1_t_d [4][3];
  wft_pkg::val_t    s1_t_q [4][3];
  logic [CoW-1:0]   s1_co_d, s1_co_q;
  logic [wft_pkg::ChanW-1:0] s1_o_q;

  always_comb begin
    logic signed [17:0] wt [3][3];
    wft_pkg::val_t a, b, d, sum_p, sum_m;
    wt[0][0] = {in_req_i.w00, 2'b00};
    wt[0][1] = {in_req_i.w01, 2'b00};
    wt[0][2] = {in_req_i.w02, 2'b00};
    wt[1][0] = {in_req_i.w10, 2'b00};
    wt[1][1] = {in_req_i.w11, 2'b00};
    wt[1][2] = {in_req_i.w12, 2'b00};
    wt[2][0] = {in_req_i.w20, 2'b00};
    wt[2][1] = {in_req_i.w21, 2'b00};
    wt[2][2] = {in_req_i.w22, 2'b00};
    for (int s = 0; s < 3; s++) begin
      a     = ValW'(wt[0][s]);
      b     = ValW'(wt[1][s]);
      d     = ValW'(wt[2][s]);
      sum_p = a + b + d;
      sum_m = a - b + d;
      s1_t_d[0][s] = a;
      s1_t_d[1][s] = sum_p >>> 1;
      s1_t_d[2][s] = sum_m >>> 1;
      s1_t_d[3][s] = d;
    end
    s1_co_d = CoW'(in_req_i.in_chan) * CoW'(num_outputs_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_t_q  <= s1_t_d;
      s1_co_q <= s1_co_d;
      s1_o_q  <= in_req_i.out_chan;
    end
  end

  // Stage 2: apply G along each row; form the row 0 index c*O + o.
  wft_pkg::val_t   s2_tile_d [4][4];
  wft_pkg::val_t   s2_tile_q [4][4];
  logic [IdxW-1:0] s2_base_q;

  always_comb begin
    logic signed [ValW+1:0] a, b, d, sum_p, sum_m;
    for (int xi = 0; xi < 4; xi++) begin
      a     = (ValW+2)'(s1_t_q[xi][0]);
      b     = (ValW+2)'(s1_t_q[xi][1]);
      d     = (ValW+2)'(s1_t_q[xi][2]);
      sum_p = a + b + d;
      sum_m = a - b + d;
      s2_tile_d[xi][0] = s1_t_q[xi][0];
      s2_tile_d[xi][1] = sum_p[ValW:1];
      s2_tile_d[xi][2] = sum_m[ValW:1];
      s2_tile_d[xi][3] = s1_t_q[xi][2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_tile_q <= s2_tile_d;
      s2_base_q <= IdxW'(s1_co_q) + IdxW'(s1_o_q);
    end
  end

  // Stage 3: output buffer; rows shift up one per taken result, index steps by 4*O*C.
  wft_pkg::val_t   s3_rows_q [4][4];
  logic [IdxW-1:0] s3_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s3_row_q   <= 2'd0;
    end else if (s3_load) begin
      s3_valid_q <= 1'b1;
      s3_row_q   <= 2'd0;
    end else if (out_take) begin
      if (s3_last) begin
        s3_valid_q <= 1'b0;
      end
      s3_row_q <= s3_row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      s3_rows_q <= s2_tile_q;
      s3_base_q <= s2_base_q;
    end else if (out_take) begin
      for (int i = 0; i < 3; i++) begin
        s3_rows_q[i] <= s3_rows_q[i+1];
      end
      s3_base_q <= s3_base_q + step_q;
    end
  end

  // Result fields.
  assign out_valid_o          = s3_valid_q;
  assign out_rsp_o.tile_row   = s3_row_q;
  assign out_rsp_o.val0       = s3_rows_q[0][0];
  assign out_rsp_o.val1       = s3_rows_q[0][1];
  assign out_rsp_o.val2       = s3_rows_q[0][2];
  assign out_rsp_o.val3       = s3_rows_q[0][3];
  assign out_rsp_o.base_index = s3_base_q;
  assign out_rsp_o.last_row   = s3_last;

  // A fresh tile always starts at row 0.
  `WFT_ASSERT(a_first_row, out_valid_o && !$past(out_valid_o) |-> out_rsp_o.tile_row == 2'd0, "tile did not start at row 0")
  // A taken row that is not the last is followed at once by the next row.
  `WFT_ASSERT(a_row_follows, out_valid_o && out_ready_i && !out_rsp_o.last_row |=> out_valid_o && out_rsp_o.tile_row == $past(out_rsp_o.tile_row) + 2'd1, "row sequence broken")
  // Row indexes advance by four times O*C.
  `WFT_ASSERT(a_base_step, out_valid_o && out_ready_i && !out_rsp_o.last_row |=> out_rsp_o.base_index == $past(out_rsp_o.base_index) + step_q, "row index step wrong")
  // An accepted request is held in the first stage on the next cycle.
  `WFT_ASSERT(a_accept_lands, in_valid_i && in_ready_o |=> s1_valid_q, "accepted request lost")
  // Stored channel counts never exceed the supported maximum.
  `WFT_ASSERT(a_count_range, num_outputs_q <= wft_pkg::CfgW'(wft_pkg::MaxChannels) && num_channels_q <= wft_pkg::CfgW'(wft_pkg::MaxChannels), "channel count out of range")

endmodule
